// ===== src/binary_volume_disk_brush_unit_assert.svh =====
// Assertion macros for the binary volume disk brush unit.
// Used by binary_volume_disk_brush_unit.sv; expects clk_i and rst_ni in scope.
`ifndef BINARY_VOLUME_DISK_BRUSH_UNIT_ASSERT_SVH
`define BINARY_VOLUME_DISK_BRUSH_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BVDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define BVDB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/bvdb_pkg.sv =====
// Shared types, constants and the brush half-width table of the disk brush unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bvdb_pkg;

  localparam int X_DIM      = 64;
  localparam int Y_DIM      = 64;
  localparam int Z_DIM      = 16;
  localparam int MAX_RADIUS = 15;

  localparam int X_IDX_W   = $clog2(X_DIM);
  localparam int Y_IDX_W   = $clog2(Y_DIM);
  localparam int Z_IDX_W   = $clog2(Z_DIM);
  localparam int ADDR_W    = Z_IDX_W + Y_IDX_W;
  localparam int MEM_DEPTH = Z_DIM * Y_DIM;
  localparam int RAD_W     = 4;
  localparam int STEP_W    = RAD_W + 1;
  localparam int CLIP_W    = 6;
  localparam int COORD_W   = 10;
  localparam int CFG_IDX_W = 3;

  typedef logic [X_DIM-1:0]          row_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [RAD_W-1:0]          radius_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [CLIP_W-1:0]         clip_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [STEP_W:0]    offset_t;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_UNSET = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 3'd0,
    CFG_X_MIN  = 3'd1,
    CFG_X_MAX  = 3'd2,
    CFG_Y_MIN  = 3'd3,
    CFG_Y_MAX  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RDATA,
    ST_PAINT,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    radius_t brush_radius;
    clip_t   clip_x_min;
    clip_t   clip_x_max;
    clip_t   clip_y_min;
    clip_t   clip_y_max;
  } cfg_t;

  typedef struct packed {
    logic  vld;
    addr_t addr;
    row_t  mask;
  } pend_t;

  typedef struct packed {
    logic status;
    logic voxel_value;
  } res_t;

  localparam int TAB_N = 2 ** (2 * RAD_W);

  // half width isqrt(r*r - a*a), indexed by {r, a}
  function automatic logic [TAB_N-1:0][RAD_W-1:0] calc_half_w();
    logic [TAB_N-1:0][RAD_W-1:0] t;
    int v;
    int s;
    t = '0;
    for (int r = 0; r < 2 ** RAD_W; r++) begin
      for (int a = 0; a < 2 ** RAD_W; a++) begin
        v = r * r - a * a;
        s = 0;
        for (int k = 1; k < 2 ** RAD_W; k++) begin
          if (k * k <= v) s = k;
        end
        t[r * (2 ** RAD_W) + a] = RAD_W'(s);
      end
    end
    return t;
  endfunction

  localparam logic [TAB_N-1:0][RAD_W-1:0] HALF_W_TAB = calc_half_w();

endpackage

// ===== src/bvdb_cfg_regs.sv =====
// Configuration registers of the disk brush unit: radius and clip window.
// Depends on bvdb_pkg.
`timescale 1ns / 1ps

module bvdb_cfg_regs import bvdb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CLIP_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brush_radius <= '0;
      cfg_q.clip_x_min   <= '0;
      cfg_q.clip_x_max   <= clip_t'(X_DIM - 1);
      cfg_q.clip_y_min   <= '0;
      cfg_q.clip_y_max   <= clip_t'(Y_DIM - 1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS: cfg_q.brush_radius <= cfg_data_i[RAD_W-1:0];
        CFG_X_MIN:  cfg_q.clip_x_min   <= cfg_data_i;
        CFG_X_MAX:  cfg_q.clip_x_max   <= cfg_data_i;
        CFG_Y_MIN:  cfg_q.clip_y_min   <= cfg_data_i;
        CFG_Y_MAX:  cfg_q.clip_y_max   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/bvdb_row_mem.sv =====
// Voxel row memory: one packed row word per slice and row, one write and one read port.
// Depends on bvdb_pkg; read data is registered.
`timescale 1ns / 1ps

module bvdb_row_mem import bvdb_pkg::*; (
  input  logic  clk_i,
  input  logic  wr_en_i,
  input  addr_t wr_addr_i,
  input  row_t  wr_data_i,
  input  logic  rd_en_i,
  input  addr_t rd_addr_i,
  output row_t  rd_data_o
);

  row_t mem_q [MEM_DEPTH];
  row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/bvdb_span.sv =====
// Span stage: turns one brush row offset into a clipped row address and bit mask.
// Depends on bvdb_pkg; issues the row read and holds the mask for the write-back.
`timescale 1ns / 1ps

module bvdb_span import bvdb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  coord_t              cx_i,
  input  coord_t              cy_i,
  input  logic [Z_IDX_W-1:0]  z_i,
  input  offset_t             dy_i,
  input  radius_t             r_i,
  input  cfg_t                cfg_i,
  output logic                rd_en_o,
  output addr_t               rd_addr_o,
  output pend_t               pend_o
);

  offset_t              ady_full;
  radius_t              ady;
  radius_t              w;
  coord_t               w_s;
  coord_t               y;
  coord_t               x_lo_raw;
  coord_t               x_hi_raw;
  coord_t               x_lo;
  coord_t               x_hi;
  coord_t               x_min_s;
  coord_t               x_max_s;
  coord_t               y_min_s;
  coord_t               y_max_s;
  logic                 row_ok;
  logic                 span_ok;
  logic [X_IDX_W-1:0]   hi_gap;
  row_t                 mask;
  logic                 pend_vld_q;
  addr_t                pend_addr_q;
  row_t                 pend_mask_q;

  always_comb begin
    ady_full = dy_i[STEP_W] ? -dy_i : dy_i;
    ady      = ady_full[RAD_W-1:0];
    w        = HALF_W_TAB[{r_i, ady}];
    w_s      = $signed({{(COORD_W-RAD_W){1'b0}}, w});
    y        = cy_i + $signed({{(COORD_W-STEP_W-1){dy_i[STEP_W]}}, dy_i});
    x_min_s  = $signed({{(COORD_W-CLIP_W){1'b0}}, cfg_i.clip_x_min});
    x_max_s  = $signed({{(COORD_W-CLIP_W){1'b0}}, cfg_i.clip_x_max});
    y_min_s  = $signed({{(COORD_W-CLIP_W){1'b0}}, cfg_i.clip_y_min});
    y_max_s  = $signed({{(COORD_W-CLIP_W){1'b0}}, cfg_i.clip_y_max});

    row_ok = (y >= y_min_s) && (y <= y_max_s) &&
             (y >= coord_t'(0)) && (y < coord_t'(Y_DIM));

    x_lo_raw = cx_i - w_s;
    x_hi_raw = cx_i + w_s;
    x_lo = (x_lo_raw > x_min_s) ? x_lo_raw : x_min_s;
    if (x_lo < coord_t'(0)) x_lo = coord_t'(0);
    x_hi = (x_hi_raw < x_max_s) ? x_hi_raw : x_max_s;
    if (x_hi > coord_t'(X_DIM - 1)) x_hi = coord_t'(X_DIM - 1);
    span_ok = (x_lo <= x_hi);

    hi_gap = X_IDX_W'(X_DIM - 1) - x_hi[X_IDX_W-1:0];
    mask   = ({X_DIM{1'b1}} << x_lo[X_IDX_W-1:0]) & ({X_DIM{1'b1}} >> hi_gap);
  end

  assign rd_en_o   = step_i && row_ok && span_ok;
  assign rd_addr_o = {z_i, y[Y_IDX_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else begin
      pend_vld_q <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) begin
      pend_addr_q <= rd_addr_o;
      pend_mask_q <= mask;
    end
  end

  assign pend_o.vld  = pend_vld_q;
  assign pend_o.addr = pend_addr_q;
  assign pend_o.mask = pend_mask_q;

endmodule

// ===== src/binary_volume_disk_brush_unit.sv =====
// Binary voxel volume with a disk brush: top level with the request sequencer.
// Instantiates bvdb_cfg_regs, bvdb_row_mem and bvdb_span; depends on bvdb_pkg.
//
// Usage: one request enters on the s_axis channel (kind in tuser, center and
// slice in tdata) and exactly one result leaves on the m_axis channel.
// Requests are handled one at a time; the next one is taken once the previous
// result sits in the output register, even while that result is stalled.
// Steps from accept to result valid:
//   read voxel   ST_READ issues the row read, ST_RDATA samples the voxel, then ST_DONE
//   paint disk   one row of the brush per cycle, rows cy-r..cy+r (r = brush radius),
//                by a read-modify-write pass over the row memory port, then ST_FLUSH
//   clear volume one memory row per cycle over every row, then ST_DONE
// After reset every row of the row memory is swept to zero with
// s_axis_tready low; configuration writes are taken throughout.
// When the receiver holds m_axis_tready low the result stays in the output
// register; one more request is taken, and s_axis_tready stays low until that register frees.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write them only while no request is in flight, the block does not enforce it.
`timescale 1ns / 1ps
`include "binary_volume_disk_brush_unit_assert.svh"

module binary_volume_disk_brush_unit import bvdb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // center_x[7:0], center_y[15:8], slice_z[19:16]
  input  logic [1:0]           s_axis_tuser,  // req_type[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // voxel_value[0], status[1]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CLIP_W-1:0]    cfg_data_i
);

  cfg_t               cfg;
  state_e             state_q, state_d;
  req_e               req_q;
  logic [7:0]         cx_q;
  logic [7:0]         cy_q;
  logic [Z_IDX_W-1:0] z_q;
  step_t              step_q, step_d;
  addr_t              clr_cnt_q, clr_cnt_d;
  logic               clr_req_q, clr_req_d;
  res_t               res_q;
  logic               out_vld_q;
  res_t               out_res_q;

  logic    in_accept;
  logic    out_free;
  logic    step_en;
  radius_t r_eff;
  coord_t  cx_s;
  coord_t  cy_s;
  offset_t dy;
  logic    rd_in_vol;
  logic    span_rd_en;
  addr_t   span_rd_addr;
  pend_t   pend;
  logic    mem_wr_en;
  addr_t   mem_wr_addr;
  row_t    mem_wr_data;
  logic    mem_rd_en;
  addr_t   mem_rd_addr;
  row_t    mem_rd_data;

  bvdb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign r_eff = (cfg.brush_radius > radius_t'(MAX_RADIUS)) ? radius_t'(MAX_RADIUS)
                                                             : cfg.brush_radius;
  assign cx_s  = $signed({{(COORD_W-8){cx_q[7]}}, cx_q});
  assign cy_s  = $signed({{(COORD_W-8){cy_q[7]}}, cy_q});
  assign dy    = $signed({1'b0, step_q}) - $signed({{(STEP_W+1-RAD_W){1'b0}}, r_eff});

  assign rd_in_vol = (cx_s >= coord_t'(0)) && (cx_s < coord_t'(X_DIM)) &&
                     (cy_s >= coord_t'(0)) && (cy_s < coord_t'(Y_DIM));

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_vld_q || m_axis_tready;

  bvdb_span u_span (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step_en),
    .cx_i      (cx_s),
    .cy_i      (cy_s),
    .z_i       (z_q),
    .dy_i      (dy),
    .r_i       (r_eff),
    .cfg_i     (cfg),
    .rd_en_o   (span_rd_en),
    .rd_addr_o (span_rd_addr),
    .pend_o    (pend)
  );

  bvdb_row_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // next state
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    clr_cnt_d = clr_cnt_q;
    clr_req_d = clr_req_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == addr_t'(MEM_DEPTH - 1)) begin
          state_d = clr_req_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          step_d    = '0;
          clr_cnt_d = '0;
          clr_req_d = 1'b1;
          case (req_e'(s_axis_tuser))
            REQ_READ:  state_d = ST_READ;
            REQ_SET:   state_d = ST_PAINT;
            REQ_UNSET: state_d = ST_PAINT;
            REQ_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_RDATA;
      ST_RDATA: state_d = ST_DONE;
      ST_PAINT: begin
        step_d = step_q + 1'b1;
        if (step_q == {r_eff, 1'b0}) state_d = ST_FLUSH;
      end
      ST_FLUSH: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    step_en       = (state_q == ST_PAINT);
    mem_rd_en     = 1'b0;
    mem_rd_addr   = span_rd_addr;
    mem_wr_en     = pend.vld;
    mem_wr_addr   = pend.addr;
    mem_wr_data   = (req_q == REQ_SET) ? (mem_rd_data | pend.mask)
                                       : (mem_rd_data & ~pend.mask);
    case (state_q)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_q;
        mem_wr_data = '0;
      end
      ST_READ: begin
        mem_rd_en   = rd_in_vol;
        mem_rd_addr = {z_q, cy_q[Y_IDX_W-1:0]};
      end
      ST_PAINT: mem_rd_en = span_rd_en;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      clr_cnt_q <= '0;
      clr_req_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      clr_cnt_q <= clr_cnt_d;
      clr_req_q <= clr_req_d;
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // hold request fields and result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_e'(s_axis_tuser);
      cx_q  <= s_axis_tdata[7:0];
      cy_q  <= s_axis_tdata[15:8];
      z_q   <= s_axis_tdata[16 +: Z_IDX_W];
      res_q <= '0;
    end else if (state_q == ST_RDATA) begin
      res_q.status      <= !rd_in_vol;
      res_q.voxel_value <= rd_in_vol && mem_rd_data[cx_q[X_IDX_W-1:0]];
    end
    if (state_q == ST_DONE && out_free) out_res_q <= res_q;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_res_q.status, out_res_q.voxel_value};

  `BVDB_ASSERT_NEVER(a_rw_same_row, mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr), "row read and write collide")
  `BVDB_ASSERT(a_pend_in_paint, pend.vld |-> (state_q == ST_PAINT || state_q == ST_FLUSH), "write-back outside paint pass")
  `BVDB_ASSERT(a_accept_leaves_idle, in_accept |=> (state_q != ST_IDLE), "request accepted without work")
  `BVDB_ASSERT(a_sweep_steps, (state_q == ST_CLEAR && $past(state_q == ST_CLEAR) && $past(rst_ni)) |-> (clr_cnt_q == addr_t'($past(clr_cnt_q) + 1'b1)), "clear sweep skipped a row")

endmodule

// ===== test/tb_binary_volume_disk_brush_unit.sv =====
`timescale 1ns / 1ps
// Testbench for binary_volume_disk_brush_unit: directed and random voxel reads, disk paints
// and clears, checked against a voxel image predicted inside the bench.
// Depends on bvdb_pkg and the RTL under src.

module tb_binary_volume_disk_brush_unit;
  import bvdb_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int RX_HOLD_AT = 300;
  localparam int RX_HOLD_LEN = 400;
  localparam int MAX_REPORTS = 200;

  typedef struct {
    req_e              kind;
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    logic [3:0]        z;
  } brush_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CLIP_W-1:0]    cfg_data_i = '0;

  brush_req_t brush_req_q[$];
  res_t       voxel_results_q[$];
  row_t       voxel_image[MEM_DEPTH];
  int         brush_r;
  int         win_x_lo;
  int         win_x_hi;
  int         win_y_lo;
  int         win_y_hi;

  brush_req_t tx_req;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         rx_hold = 0;
  int         rx_count = 0;
  int         idle_cycles = 0;
  int         errors = 0;
  bit         quiet = 1'b0;
  int         last_cx = 32;
  int         last_cy = 32;

  binary_volume_disk_brush_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int floor_root(int v);
    int s;
    s = 0;
    while ((s + 1) * (s + 1) <= v) s++;
    return s;
  endfunction

  function automatic void mark_voxel(int x, int y, int z, bit val);
    if (x < win_x_lo || x > win_x_hi || y < win_y_lo || y > win_y_hi) return;
    if (x < 0 || x >= X_DIM || y < 0 || y >= Y_DIM || z < 0 || z >= Z_DIM) return;
    voxel_image[z * Y_DIM + y][x] = val;
  endfunction

  function automatic void paint_brush(int cx, int cy, int z, bit val);
    int r;
    int h;
    r = brush_r;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    if (r == 0) begin
      mark_voxel(cx, cy, z, val);
      return;
    end
    for (int d = -r + 1; d < r; d++) begin
      h = floor_root(r * r - d * d);
      for (int k = -h; k <= h; k++) mark_voxel(cx + k, cy + d, z, val);
    end
    for (int d = -r + 1; d < r; d++) begin
      h = floor_root(r * r - d * d);
      mark_voxel(cx + d, cy + h, z, val);
      mark_voxel(cx + d, cy, z, val);
      mark_voxel(cx + d, cy - h, z, val);
    end
  endfunction

  function automatic res_t predict_voxel_result(logic [1:0] kind, logic [23:0] data);
    res_t res;
    int   cx;
    int   cy;
    int   z;
    res = '0;
    cx = int'($signed(data[7:0]));
    cy = int'($signed(data[15:8]));
    z = int'(data[19:16]);
    case (kind)
      REQ_READ: begin
        if (cx >= 0 && cx < X_DIM && cy >= 0 && cy < Y_DIM && z < Z_DIM) begin
          res.voxel_value = voxel_image[z * Y_DIM + cy][cx];
        end else begin
          res.status = 1'b1;
        end
      end
      REQ_SET:   paint_brush(cx, cy, z, 1'b1);
      REQ_UNSET: paint_brush(cx, cy, z, 1'b0);
      default: begin
        foreach (voxel_image[i]) voxel_image[i] = '0;
      end
    endcase
    return res;
  endfunction

  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        voxel_results_q.push_back(predict_voxel_result(s_axis_tuser, s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (brush_req_q.size() != 0) begin
          tx_req = brush_req_q.pop_front();
          s_axis_tuser  <= tx_req.kind;
          s_axis_tdata  <= {4'b0, tx_req.z, tx_req.cy, tx_req.cx};
          s_axis_tvalid <= 1'b1;
          tx_gap = idle_draw();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (voxel_results_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: result with no request pending, expected none, actual %h",
                     $time, m_axis_tdata);
          end
        end else begin
          exp_res = voxel_results_q.pop_front();
          if (m_axis_tdata[0] !== exp_res.voxel_value) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: voxel_value mismatch, expected %0b, actual %0b",
                       $time, exp_res.voxel_value, m_axis_tdata[0]);
            end
          end
          if (m_axis_tdata[1] !== exp_res.status) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: status mismatch, expected %0b, actual %0b",
                       $time, exp_res.status, m_axis_tdata[1]);
            end
          end
        end
        rx_count++;
        rx_gap = idle_draw();
        if (rx_count == RX_HOLD_AT) rx_hold = RX_HOLD_LEN;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CLIP_W'(val);
    case (idx)
      CFG_RADIUS: brush_r  = val & 15;
      CFG_X_MIN:  win_x_lo = val & 63;
      CFG_X_MAX:  win_x_hi = val & 63;
      CFG_Y_MIN:  win_y_lo = val & 63;
      default:    win_y_hi = val & 63;
    endcase
  endtask

  task automatic set_brush(int r, int xl, int xh, int yl, int yh);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_X_MIN, xl);
    write_reg(CFG_X_MAX, xh);
    write_reg(CFG_Y_MIN, yl);
    write_reg(CFG_Y_MAX, yh);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_req(req_e kind, int x, int y, int z);
    brush_req_t req;
    req.kind = kind;
    req.cx = 8'(x);
    req.cy = 8'(y);
    req.z = 4'(z);
    brush_req_q.push_back(req);
  endtask

  task automatic queue_random_req();
    int   pick;
    int   x;
    int   y;
    int   z;
    req_e kind;
    pick = $urandom_range(0, 99);
    if (pick < 45) kind = REQ_READ;
    else if (pick < 72) kind = REQ_SET;
    else if (pick < 97) kind = REQ_UNSET;
    else kind = REQ_CLEAR;
    if (kind == REQ_READ && $urandom_range(0, 1) == 1) begin
      x = last_cx + $urandom_range(0, 32) - 16;
      y = last_cy + $urandom_range(0, 32) - 16;
    end else if ($urandom_range(0, 9) < 8) begin
      x = $urandom_range(0, 63);
      y = $urandom_range(0, 63);
    end else begin
      x = $urandom_range(0, 191) - 64;
      y = $urandom_range(0, 191) - 64;
    end
    z = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(0, 15);
    if ((kind == REQ_SET || kind == REQ_UNSET) && x >= 0 && x < X_DIM && y >= 0 && y < Y_DIM)
    begin
      last_cx = x;
      last_cy = y;
    end
    queue_req(kind, x, y, z);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (brush_req_q.size() != 0 || s_axis_tvalid || voxel_results_q.size() != 0);
  endtask

  initial begin
    int xa;
    int xb;
    int ya;
    int yb;
    foreach (voxel_image[i]) voxel_image[i] = '0;
    brush_r = 0;
    win_x_lo = 0;
    win_x_hi = 63;
    win_y_lo = 0;
    win_y_hi = 63;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_brush(0, 0, 63, 0, 63);
    queue_req(REQ_SET, 0, 0, 0);
    queue_req(REQ_READ, 0, 0, 0);
    queue_req(REQ_SET, 63, 63, 15);
    queue_req(REQ_READ, 63, 63, 15);
    queue_req(REQ_READ, -1, 0, 0);
    queue_req(REQ_READ, 64, 5, 3);
    queue_req(REQ_READ, 0, -64, 0);
    queue_req(REQ_READ, 127, 127, 15);
    queue_req(REQ_UNSET, 0, 0, 0);
    queue_req(REQ_READ, 0, 0, 0);
    wait_drained();

    set_brush(15, 0, 63, 0, 63);
    queue_req(REQ_SET, 32, 32, 5);
    queue_req(REQ_READ, 47, 32, 5);
    queue_req(REQ_READ, 32, 47, 5);
    queue_req(REQ_READ, 48, 32, 5);
    queue_req(REQ_SET, -10, 70, 2);
    queue_req(REQ_READ, 0, 60, 2);
    queue_req(REQ_SET, -64, -64, 1);
    queue_req(REQ_SET, 127, 127, 1);
    queue_req(REQ_UNSET, 32, 32, 5);
    queue_req(REQ_READ, 32, 32, 5);
    wait_drained();

    set_brush(7, 10, 30, 5, 50);
    queue_req(REQ_SET, 10, 5, 0);
    queue_req(REQ_READ, 10, 5, 0);
    queue_req(REQ_READ, 9, 5, 0);
    queue_req(REQ_CLEAR, 0, 0, 0);
    queue_req(REQ_READ, 10, 5, 0);
    queue_req(REQ_READ, 63, 63, 15);
    wait_drained();

    set_brush(3, 40, 20, 0, 63);
    queue_req(REQ_SET, 30, 30, 3);
    queue_req(REQ_READ, 30, 30, 3);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      xa = $urandom_range(0, 63);
      xb = $urandom_range(0, 63);
      ya = $urandom_range(0, 63);
      yb = $urandom_range(0, 63);
      if (xa > xb) begin
        xa = xa ^ xb;
        xb = xa ^ xb;
        xa = xa ^ xb;
      end
      if (ya > yb) begin
        ya = ya ^ yb;
        yb = ya ^ yb;
        ya = ya ^ yb;
      end
      case (p)
        0: set_brush(15, 0, 63, 0, 63);
        1: set_brush(0, 0, 63, 0, 63);
        2: set_brush(1, xa, xa, ya, yb);
        3: set_brush($urandom_range(0, 15), 63, 0, ya, yb);
        4: set_brush($urandom_range(0, 15), xa, xb, 63, 0);
        5: set_brush(15, xa, xb, ya, yb);
        default: set_brush($urandom_range(0, 15), xa, xb, ya, yb);
      endcase
      quiet = (p % 3 == 2);
      for (int i = 0; i < 110; i++) queue_random_req();
      wait_drained();
    end

    quiet = 1'b0;
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bvdb_pkg.sv
src/bvdb_cfg_regs.sv
src/bvdb_row_mem.sv
src/bvdb_span.sv
src/binary_volume_disk_brush_unit.sv
test/tb_binary_volume_disk_brush_unit.sv
